[design/crcfr_pkg.sv]
// Shared types, codes and the byte-wide CRC-16 update for the frame receiver.
package crcfr_pkg;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [WORD_W-1:0] CRC_TOP  = 16'h8000;

  // Frame status codes.
  localparam logic [STATUS_W-1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CRC_ERR  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TAIL_ERR = 2'd3;

  // Configuration register indexes.
  localparam int REG_HEADER = 0;
  localparam int REG_TAIL   = 1;
  localparam int REG_KIND0  = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              burst_end;
  } in_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind_index;
    logic [BYTE_W-1:0]   payload_value;
    logic [BYTE_W-1:0]   payload_pos;
    logic [STATUS_W-1:0] frame_status;
    logic                frame_done;
  } out_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] header_word;
    logic [WORD_W-1:0] tail_word;
  } cfg_regs_t;

  // Output buffer handshake between the deframer and the result buffer.
  typedef struct packed {
    logic     push;
    out_req_t data;
  } obuf_push_t;

  // MSB-first CRC-16 update over one byte, no reflection.
  function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {b, {(WORD_W - BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if ((c & CRC_TOP) != '0) begin
        c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[WORD_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[design/crc16_framed_packet_receiver_core.sv]
// Throughput: one byte per cycle while the result buffer has space; the frame state
// machine and the byte-wide CRC update sit between the input register and the
// two-entry result buffer. A stalled output holds up input only once both result
// entries are full. Reset (rst_n, synchronous, active low) clears all but the data
// registers and returns the deframer to hunting the first header byte with the CRC
// at 0xFFFF.
module crc16_framed_packet_receiver_core
  import crcfr_pkg::*;
#(
  parameter int NUM_KINDS = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  in_req_t                             in_data,
  output logic                                in_stall,
  output logic                                out_valid,
  output out_req_t                            out_data,
  input  logic                                out_stall,
  input  logic                                cfg_we,
  input  logic [$clog2(NUM_KINDS + 2)-1:0]    cfg_idx,
  input  logic [WORD_W-1:0]                   cfg_wdata
);

  localparam int CFG_IDX_W = $clog2(NUM_KINDS + 2);

  cfg_regs_t                        regs;
  logic [NUM_KINDS-1:0][WORD_W-1:0] kind_tbl;
  logic                             obuf_space;
  obuf_push_t                       obuf_wr;

  crcfr_regs #(
    .NUM_KINDS (NUM_KINDS),
    .CFG_IDX_W (CFG_IDX_W)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .regs      (regs),
    .kind_tbl  (kind_tbl)
  );

  crcfr_core #(
    .NUM_KINDS (NUM_KINDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .regs       (regs),
    .kind_tbl   (kind_tbl),
    .obuf_space (obuf_space),
    .obuf_wr    (obuf_wr)
  );

  crcfr_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (obuf_wr),
    .space     (obuf_space),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

[design/crcfr_regs.sv]
// Configuration registers: header, tail and the kind table.
module crcfr_regs
  import crcfr_pkg::*;
#(
  parameter int NUM_KINDS = 5,
  parameter int CFG_IDX_W = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_idx,
  input  logic [WORD_W-1:0]                   cfg_wdata,
  output cfg_regs_t                           regs,
  output logic [NUM_KINDS-1:0][WORD_W-1:0]    kind_tbl
);

  cfg_regs_t                        regs_r;
  logic [NUM_KINDS-1:0][WORD_W-1:0] kind_tbl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r     <= '0;
      kind_tbl_r <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_IDX_W'(REG_HEADER)) begin
        regs_r.header_word <= cfg_wdata;
      end
      if (cfg_idx == CFG_IDX_W'(REG_TAIL)) begin
        regs_r.tail_word <= cfg_wdata;
      end
      for (int i = 0; i < NUM_KINDS; i++) begin
        if (cfg_idx == CFG_IDX_W'(REG_KIND0 + i)) begin
          kind_tbl_r[i] <= cfg_wdata;
        end
      end
    end
  end

  assign regs     = regs_r;
  assign kind_tbl = kind_tbl_r;

endmodule

[design/crcfr_core.sv]
// Input register and frame state machine with the running CRC check.
module crcfr_core
  import crcfr_pkg::*;
#(
  parameter int NUM_KINDS = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  in_req_t                          in_data,
  output logic                             in_stall,
  input  cfg_regs_t                        regs,
  input  logic [NUM_KINDS-1:0][WORD_W-1:0] kind_tbl,
  input  logic                             obuf_space,
  output obuf_push_t                       obuf_wr
);

  localparam int PH_W = 4;
  localparam logic [PH_W-1:0] PH_H1   = 4'd0;
  localparam logic [PH_W-1:0] PH_H2   = 4'd1;
  localparam logic [PH_W-1:0] PH_TYPE = 4'd2;
  localparam logic [PH_W-1:0] PH_LEN  = 4'd3;
  localparam logic [PH_W-1:0] PH_PAY  = 4'd4;
  localparam logic [PH_W-1:0] PH_CRCL = 4'd5;
  localparam logic [PH_W-1:0] PH_CRCH = 4'd6;
  localparam logic [PH_W-1:0] PH_T1   = 4'd7;
  localparam logic [PH_W-1:0] PH_T2   = 4'd8;

  logic              req_vld_r;
  in_req_t           req_r;
  logic              proc_go;
  logic              in_accept;

  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [WORD_W-1:0] crc_r, crc_nxt;
  logic [WORD_W-1:0] rcrc_r, rcrc_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] exp_len_r, exp_len_nxt;
  logic              tail_ok_r, tail_ok_nxt;

  logic              res_vld;
  out_req_t          res;

  assign proc_go   = req_vld_r && obuf_space;
  assign in_stall  = req_vld_r && !proc_go;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_accept || proc_go) begin
      req_vld_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_data;
    end
  end

  always_comb begin
    logic [BYTE_W-1:0] b;
    logic              hit;
    logic [KIND_W-1:0] hit_kind;
    logic [BYTE_W-1:0] hit_len;
    logic [BYTE_W-1:0] hunt_b;
    b        = req_r.rx_byte;
    hunt_b   = regs.header_word[WORD_W-1:BYTE_W];
    hit      = 1'b0;
    hit_kind = '0;
    hit_len  = '0;
    // Scan downward so the lowest enabled matching entry wins.
    for (int i = NUM_KINDS - 1; i >= 0; i--) begin
      if (kind_tbl[i][BYTE_W-1:0] != '0 && kind_tbl[i][WORD_W-1:BYTE_W] == b) begin
        hit      = 1'b1;
        hit_kind = KIND_W'(i);
        hit_len  = kind_tbl[i][BYTE_W-1:0];
      end
    end

    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    rcrc_nxt    = rcrc_r;
    kind_nxt    = kind_r;
    cnt_nxt     = cnt_r;
    exp_len_nxt = exp_len_r;
    tail_ok_nxt = tail_ok_r;
    res_vld     = 1'b0;
    res         = '0;

    case (phase_r)
      PH_H1: begin
        phase_nxt = (b == hunt_b) ? PH_H2 : PH_H1;
      end
      PH_H2: begin
        if (b == regs.header_word[BYTE_W-1:0]) begin
          phase_nxt = PH_TYPE;
        end else begin
          phase_nxt = (b == hunt_b) ? PH_H2 : PH_H1;
        end
      end
      PH_TYPE: begin
        if (hit) begin
          kind_nxt    = hit_kind;
          exp_len_nxt = hit_len;
          crc_nxt     = crc16_byte(CRC_INIT, b);
          phase_nxt   = PH_LEN;
        end else begin
          phase_nxt = (b == hunt_b) ? PH_H2 : PH_H1;
        end
      end
      PH_LEN: begin
        if (b == exp_len_r && exp_len_r != '0) begin
          crc_nxt   = crc16_byte(crc_r, b);
          cnt_nxt   = '0;
          phase_nxt = PH_PAY;
        end else begin
          phase_nxt = (b == hunt_b) ? PH_H2 : PH_H1;
        end
      end
      PH_PAY: begin
        res_vld           = 1'b1;
        res.kind_index    = kind_r;
        res.payload_value = b;
        res.payload_pos   = cnt_r;
        res.frame_status  = ST_PAYLOAD;
        res.frame_done    = 1'b0;
        crc_nxt           = crc16_byte(crc_r, b);
        cnt_nxt           = cnt_r + BYTE_W'(1);
        if (cnt_nxt >= exp_len_r) begin
          phase_nxt = PH_CRCL;
        end
      end
      PH_CRCL: begin
        rcrc_nxt  = {{(WORD_W - BYTE_W){1'b0}}, b};
        phase_nxt = PH_CRCH;
      end
      PH_CRCH: begin
        rcrc_nxt  = {b, rcrc_r[BYTE_W-1:0]};
        phase_nxt = PH_T1;
      end
      PH_T1: begin
        tail_ok_nxt = (b == regs.tail_word[WORD_W-1:BYTE_W]);
        phase_nxt   = PH_T2;
      end
      PH_T2: begin
        res_vld           = 1'b1;
        res.kind_index    = kind_r;
        res.payload_value = '0;
        res.payload_pos   = cnt_r;
        res.frame_done    = 1'b1;
        // Tail error takes priority over CRC error.
        if (!(tail_ok_r && b == regs.tail_word[BYTE_W-1:0])) begin
          res.frame_status = ST_TAIL_ERR;
        end else if (rcrc_r != crc_r) begin
          res.frame_status = ST_CRC_ERR;
        end else begin
          res.frame_status = ST_GOOD;
        end
        tail_ok_nxt = 1'b0;
        phase_nxt   = PH_H1;
      end
      default: begin
        phase_nxt = PH_H1;
      end
    endcase

    // Burst end: close a frame that has reached its payload as cut short, then hunt again.
    if (req_r.burst_end) begin
      if (phase_nxt inside {[PH_PAY:PH_T2]}) begin
        res_vld           = 1'b1;
        res.kind_index    = kind_nxt;
        res.payload_value = '0;
        res.payload_pos   = cnt_nxt;
        res.frame_status  = ST_TAIL_ERR;
        res.frame_done    = 1'b1;
      end
      phase_nxt = PH_H1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_H1;
      crc_r     <= CRC_INIT;
      rcrc_r    <= '0;
      kind_r    <= '0;
      cnt_r     <= '0;
      exp_len_r <= '0;
      tail_ok_r <= 1'b0;
    end else if (proc_go) begin
      phase_r   <= phase_nxt;
      crc_r     <= crc_nxt;
      rcrc_r    <= rcrc_nxt;
      kind_r    <= kind_nxt;
      cnt_r     <= cnt_nxt;
      exp_len_r <= exp_len_nxt;
      tail_ok_r <= tail_ok_nxt;
    end
  end

  assign obuf_wr.push = proc_go && res_vld;
  assign obuf_wr.data = res;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_T2)
    else $error("frame phase out of range");

  a_pay_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> cnt_r < exp_len_r)
    else $error("payload count reached length while still in payload");

  a_pay_status: assert property (@(posedge clk) disable iff (!rst_n)
    obuf_wr.push && !obuf_wr.data.frame_done |->
      obuf_wr.data.frame_status == ST_PAYLOAD)
    else $error("non-closing request carries a closing status");
`endif

endmodule

[design/crcfr_obuf.sv]
// Two-entry result buffer: output register plus skid register.
module crcfr_obuf
  import crcfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  obuf_push_t wr,
  output logic       space,
  output logic       out_valid,
  output out_req_t   out_data,
  input  logic       out_stall
);

  logic     head_vld_r;
  logic     skid_vld_r;
  out_req_t head_r;
  out_req_t skid_r;
  logic     pop;

  assign pop   = head_vld_r && !out_stall;
  assign space = !skid_vld_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      head_vld_r <= skid_vld_r || wr.push;
      skid_vld_r <= skid_vld_r && wr.push;
    end else if (wr.push) begin
      head_vld_r <= 1'b1;
      skid_vld_r <= head_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head_r <= skid_vld_r ? skid_r : wr.data;
      if (skid_vld_r && wr.push) begin
        skid_r <= wr.data;
      end
    end else if (wr.push) begin
      if (!head_vld_r) begin
        head_r <= wr.data;
      end else begin
        skid_r <= wr.data;
      end
    end
  end

  assign out_valid = head_vld_r;
  assign out_data  = head_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr.push |-> space)
    else $error("request pushed into a full result buffer");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> head_vld_r)
    else $error("skid entry held without an output entry");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(head_vld_r && out_stall))
    else $error("skid entry filled while output was free");
`endif

endmodule

[bench/tb.sv]
// Self-checking bench for the CRC-16 framed packet receiver core.
module tb;
  import crcfr_pkg::*;

  localparam int N_KINDS     = 5;
  localparam int CFG_IDX_W   = $clog2(N_KINDS + 2);
  localparam int REG_SPARE   = REG_KIND0 + N_KINDS;
  localparam int SETTLE      = 6;
  localparam int PHASE_ITEMS = 120;
  localparam int LIMIT       = 2000;

  typedef enum logic [3:0] {
    SEEK_H1, SEEK_H2, TAKE_TYPE, TAKE_LEN, TAKE_PAYLOAD,
    TAKE_CRC_LO, TAKE_CRC_HI, TAKE_TAIL1, TAKE_TAIL2
  } rx_phase_t;

  typedef enum int {
    CLEAN, BAD_CRC, BAD_TAIL, BAD_BOTH, CUT_SHORT, BAD_TYPE, BAD_LEN, EXTRA_SYNC
  } flaw_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  in_req_t              in_data = '0;
  logic                 in_stall;
  logic                 out_valid;
  out_req_t             out_data;
  logic                 out_stall = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;

  // register shadow
  logic [15:0] hdr_cfg = 16'h0000;
  logic [15:0] tail_cfg = 16'h0000;
  logic [15:0] kind_cfg [N_KINDS] = '{default: '0};

  // deframer state mirror
  rx_phase_t   ph = SEEK_H1;
  logic [15:0] crc_acc = CRC_INIT;
  logic [15:0] rx_crc = 16'h0000;
  logic [2:0]  cur_kind = 3'd0;
  logic [7:0]  pay_cnt = 8'd0;
  logic [7:0]  exp_len = 8'd0;
  logic        tail_hit = 1'b0;

  in_req_t  feed [$];
  out_req_t expect_q [$];
  out_req_t want;
  int       queued;
  int       err_cnt = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       stall_pick;
  int       quiet_cycles = 0;
  bit       smooth_in = 1'b0;
  bit       smooth_out = 1'b0;

  crc16_framed_packet_receiver_core #(
    .NUM_KINDS(N_KINDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bit-serial CRC-16/CCITT-FALSE update, MSB first.
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic rx_phase_t hunt_next(input logic [7:0] b);
    if (b == hdr_cfg[15:8]) begin
      return SEEK_H2;
    end
    return SEEK_H1;
  endfunction

  function automatic int idle_len(input bit smooth);
    int r;
    r = $urandom_range(0, 99);
    if (smooth || r < 65) begin
      return 0;
    end
    if (r < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Advance the deframer mirror by one byte and queue the result it gives.
  function automatic void predict_byte(input in_req_t it);
    logic [7:0] b;
    logic       have;
    logic       found;
    out_req_t   r;
    b = it.rx_byte;
    have = 1'b0;
    found = 1'b0;
    r = '0;
    case (ph)
      SEEK_H1: ph = hunt_next(b);
      SEEK_H2: begin
        if (b == hdr_cfg[7:0]) ph = TAKE_TYPE;
        else ph = hunt_next(b);
      end
      TAKE_TYPE: begin
        // lowest enabled entry with a matching type wins
        for (int i = 0; i < N_KINDS; i++) begin
          if (!found && kind_cfg[i][7:0] != 8'd0 && kind_cfg[i][15:8] == b) begin
            found = 1'b1;
            cur_kind = 3'(i);
            exp_len = kind_cfg[i][7:0];
          end
        end
        if (found) begin
          crc_acc = crc_next(CRC_INIT, b);
          ph = TAKE_LEN;
        end else begin
          ph = hunt_next(b);
        end
      end
      TAKE_LEN: begin
        if (b == exp_len && exp_len != 8'd0) begin
          crc_acc = crc_next(crc_acc, b);
          pay_cnt = 8'd0;
          ph = TAKE_PAYLOAD;
        end else begin
          ph = hunt_next(b);
        end
      end
      TAKE_PAYLOAD: begin
        r.kind_index = cur_kind;
        r.payload_value = b;
        r.payload_pos = pay_cnt;
        r.frame_status = ST_PAYLOAD;
        r.frame_done = 1'b0;
        have = 1'b1;
        crc_acc = crc_next(crc_acc, b);
        pay_cnt = pay_cnt + 8'd1;
        if (pay_cnt >= exp_len) ph = TAKE_CRC_LO;
      end
      TAKE_CRC_LO: begin
        rx_crc = {8'h00, b};
        ph = TAKE_CRC_HI;
      end
      TAKE_CRC_HI: begin
        rx_crc[15:8] = b;
        ph = TAKE_TAIL1;
      end
      TAKE_TAIL1: begin
        tail_hit = (b == tail_cfg[15:8]);
        ph = TAKE_TAIL2;
      end
      TAKE_TAIL2: begin
        r.kind_index = cur_kind;
        r.payload_pos = pay_cnt;
        r.frame_done = 1'b1;
        // a bad tail outranks a bad CRC
        if (!(tail_hit && b == tail_cfg[7:0])) r.frame_status = ST_TAIL_ERR;
        else if (rx_crc != crc_acc) r.frame_status = ST_CRC_ERR;
        else r.frame_status = ST_GOOD;
        tail_hit = 1'b0;
        have = 1'b1;
        ph = SEEK_H1;
      end
      default: ph = SEEK_H1;
    endcase
    if (it.burst_end) begin
      // burst end inside an accepted frame closes it as cut short
      if (ph >= TAKE_PAYLOAD) begin
        r = '0;
        r.kind_index = cur_kind;
        r.payload_pos = pay_cnt;
        r.frame_status = ST_TAIL_ERR;
        r.frame_done = 1'b1;
        have = 1'b1;
      end
      ph = SEEK_H1;
    end
    if (have) expect_q.push_back(r);
  endfunction

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) predict_byte(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (feed.size() != 0) begin
          in_data <= feed.pop_front();
          in_valid <= 1'b1;
          gap_left <= idle_len(smooth_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d value %0h pos %0d status %0d done %0b",
                   $time, out_data.kind_index, out_data.payload_value, out_data.payload_pos,
                   out_data.frame_status, out_data.frame_done);
          err_cnt++;
        end else begin
          want = expect_q.pop_front();
          check_field("kind_index", want.kind_index, out_data.kind_index);
          check_field("payload_value", want.payload_value, out_data.payload_value);
          check_field("payload_pos", want.payload_pos, out_data.payload_pos);
          check_field("frame_status", want.frame_status, out_data.frame_status);
          check_field("frame_done", want.frame_done, out_data.frame_done);
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        stall_pick = idle_len(smooth_out);
        out_stall <= (stall_pick != 0);
        stall_left <= (stall_pick != 0) ? stall_pick - 1 : 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    in_req_t it;
    it.rx_byte = b;
    it.burst_end = last;
    feed.push_back(it);
    queued++;
  endtask

  task automatic apply_config(input logic [15:0] h, input logic [15:0] tw,
                              input logic [15:0] k [N_KINDS]);
    logic [15:0] val;
    for (int idx = 0; idx <= REG_SPARE; idx++) begin
      if (idx == REG_HEADER) val = h;
      else if (idx == REG_TAIL) val = tw;
      else if (idx < REG_SPARE) val = k[idx - REG_KIND0];
      else val = 16'($urandom);
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= CFG_IDX_W'(idx);
      cfg_wdata <= val;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    hdr_cfg = h;
    tail_cfg = tw;
    kind_cfg = k;
  endtask

  // Build one frame for a kind entry, damage it as asked, and queue its bytes.
  task automatic add_frame(input int entry, input flaw_t flaw);
    logic [7:0]  fb [$];
    logic [7:0]  ty;
    logic [7:0]  len;
    logic [7:0]  pb;
    logic [15:0] c;
    int          last;
    int          cut;
    ty = kind_cfg[entry][15:8];
    len = kind_cfg[entry][7:0];
    c = crc_next(CRC_INIT, ty);
    c = crc_next(c, len);
    fb = '{hdr_cfg[15:8], hdr_cfg[7:0], ty, len};
    for (int i = 0; i < len; i++) begin
      pb = 8'($urandom_range(0, 255));
      fb.push_back(pb);
      c = crc_next(c, pb);
    end
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    fb.push_back(tail_cfg[15:8]);
    fb.push_back(tail_cfg[7:0]);
    last = fb.size() - 1;
    if (flaw == BAD_CRC || flaw == BAD_BOTH)
      fb[last - 3 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    if (flaw == BAD_TAIL || flaw == BAD_BOTH)
      fb[last - 1 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    if (flaw == BAD_TYPE) fb[2] ^= 8'($urandom_range(1, 255));
    if (flaw == BAD_LEN) fb[3] ^= 8'($urandom_range(1, 255));
    if (flaw == EXTRA_SYNC) fb.push_front(hdr_cfg[15:8]);
    cut = (flaw == CUT_SHORT) ? $urandom_range(2, fb.size() - 1) : fb.size() - 1;
    for (int i = 0; i <= cut; i++)
      push_byte(fb[i], (i == cut) && (flaw == CUT_SHORT || $urandom_range(0, 9) < 3));
  endtask

  task automatic drain();
    while (feed.size() != 0 || in_valid || expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] h, input logic [15:0] tw, input bit with_long);
    logic [15:0] k [N_KINDS];
    logic [7:0]  ty;
    int          pool [$];
    int          r;
    flaw_t       flaw;
    for (int i = 0; i < N_KINDS; i++) begin
      if (with_long && i == N_KINDS - 1) begin
        k[i] = 16'hFFFF;
      end else if (i != 0 && $urandom_range(0, 4) == 0) begin
        k[i] = $urandom_range(0, 1) ? 16'h0000 : {8'($urandom_range(0, 254)), 8'h00};
      end else begin
        ty = (i != 0 && $urandom_range(0, 3) == 0) ? k[0][15:8] : 8'($urandom_range(0, 254));
        k[i] = {ty, 8'($urandom_range(1, 6))};
      end
      if (k[i][7:0] != 8'd0 && k[i][7:0] <= 8'd8) pool.push_back(i);
    end
    apply_config(h, tw, k);
    smooth_in = ($urandom_range(0, 3) == 0);
    smooth_out = ($urandom_range(0, 3) == 0);
    if (with_long) add_frame(N_KINDS - 1, CLEAN);
    queued = 0;
    while (queued < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // line noise, salted with header bytes
        repeat ($urandom_range(1, 6))
          push_byte(($urandom_range(0, 3) == 0) ? hdr_cfg[15:8] : 8'($urandom_range(0, 255)),
                    $urandom_range(0, 9) == 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) flaw = CLEAN;
        else if (r < 63) flaw = BAD_CRC;
        else if (r < 71) flaw = BAD_TAIL;
        else if (r < 76) flaw = BAD_BOTH;
        else if (r < 84) flaw = CUT_SHORT;
        else if (r < 89) flaw = BAD_TYPE;
        else if (r < 94) flaw = BAD_LEN;
        else flaw = EXTRA_SYNC;
        add_frame(pool[$urandom_range(0, pool.size() - 1)], flaw);
      end
    end
    drain();
  endtask

  initial begin
    logic [7:0] hb;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero header matches, but no kind is enabled
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    drain();

    apply_config(16'hAA55, 16'h0D0A, '{16'h0104, 16'h0201, 16'h0107, 16'h0000, 16'hFFFF});
    add_frame(1, CLEAN);
    add_frame(1, BAD_BOTH);
    // repeated first header byte, then a rejected length
    push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h05, 1'b0);
    // duplicate type resolves to entry 0, so length 7 is rejected
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h07, 1'b0);
    // burst end on a payload byte
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b1);
    drain();

    run_phase(16'hFFFF, 16'h0000, 1'b0);
    run_phase(16'h0000, 16'hFFFF, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 1'b1);
    hb = 8'($urandom_range(0, 255));
    run_phase({hb, hb}, 16'($urandom), 1'b0);
    run_phase(16'($urandom), 16'($urandom), 1'b0);
    run_phase(16'($urandom), 16'($urandom), 1'b0);

    if (err_cnt == 0 && expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[crc16_framed_packet_receiver_core.f]
design/crcfr_pkg.sv
design/crcfr_regs.sv
design/crcfr_core.sv
design/crcfr_obuf.sv
design/crc16_framed_packet_receiver_core.sv
bench/tb.sv
